[sv/gqg_pkg.sv]
// ============================================================================
// gqg_pkg
// Shared types and constants of the glyph quad generator: the payload of
// each channel, request and register codes, and small arithmetic helpers.
// ============================================================================
`default_nettype none

package gqg_pkg;

    typedef enum logic [1:0] {
        REQ_TABLE_WRITE  = 2'd0,
        REQ_STRING_START = 2'd1,
        REQ_CHAR         = 2'd2
    } req_e;

    typedef enum logic [2:0] {
        CFG_ADVANCE_WIDTH  = 3'd0,
        CFG_ADVANCE_HEIGHT = 3'd1,
        CFG_ROW_SHIFT      = 3'd2,
        CFG_GLYPH_WIDTH    = 3'd3,
        CFG_GLYPH_HEIGHT   = 3'd4,
        CFG_CELL_WIDTH     = 3'd5,
        CFG_CELL_HEIGHT    = 3'd6,
        CFG_GLYPH_OFFSET   = 3'd7
    } cfg_reg_e;

    localparam logic [7:0]  CODE_LINEFEED = 8'h0a;
    localparam logic [7:0]  CODE_SPACE    = 8'h20;
    localparam logic [7:0]  CURSOR_MAX    = 8'hff;
    localparam logic [2:0]  LAST_VERTEX   = 3'd5;
    localparam logic [16:0] UV_ONE        = 17'h10000;
    // Bound on the width of the reciprocal used for the UV scaling.
    localparam int          UV_MUL_W      = 31;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         char_code;
        logic [5:0]         cell_col;
        logic [5:0]         cell_row;
        logic               cell_mapped;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [31:0]        text_color;
    } item_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [31:0]        vertex_color;
        logic               quad_last;
    } vertex_t;

    typedef struct packed {
        logic       mapped;
        logic [5:0] row;
        logic [5:0] col;
    } glyph_entry_t;

    // Number of low zero bits of an elaboration-time constant.
    function automatic int trailing_zeros(input int value);
        int count;
        count = 0;
        for (int bit_pos = 0; bit_pos < 13; bit_pos++) begin
            if ((count == bit_pos) && !value[bit_pos]) begin
                count = bit_pos + 1;
            end
        end
        return count;
    endfunction

    // Clamp a signed 19-bit value into the signed 16-bit range.
    function automatic logic [15:0] sat16(input logic [18:0] value);
        logic [15:0] result;
        if ((value[18:15] == 4'b0000) || (value[18:15] == 4'b1111)) begin
            result = value[15:0];
        end
        else if (value[18]) begin
            result = 16'h8000;
        end
        else begin
            result = 16'h7fff;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

[sv/glyph_quad_generator_core.sv]
// ============================================================================
// glyph_quad_generator_core
// Turns a stream of string-start and character beats into six textured
// vertices per mapped glyph, using a glyph table and a bitmap font atlas.
// ============================================================================
//
//  channel   signals                          direction  beat carries
//  --------  -------------------------------  ---------  --------------------
//  item      item_valid item_ready item       in         one request
//  vertex    vertex_valid vertex_ready vertex out        one vertex
//  cfg       cfg_valid cfg_ready cfg_index    in         one register write
//            cfg_data
//
//  A mapped character holds the vertex register until its six vertices are
//  accepted, so the vertex channel paces a steady stream of glyphs. Table
//  writes, string starts, spaces, linefeeds and unmapped codes leave stage 1
//  without waiting. The first vertex follows the beat through stages 1 to 3.
//  Reset clears the glyph table through per-entry valid bits, with no sweep.
//  A stalled vertex holds the pipeline behind it; item_ready drops only when
//  every stage holds a glyph.
// ============================================================================
`default_nettype none

module glyph_quad_generator_core #(
    parameter int GLYPH_CODES  = 256,
    parameter int ATLAS_WIDTH  = 512,
    parameter int ATLAS_HEIGHT = 512
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output      logic            item_ready,
    input  wire gqg_pkg::item_t  item,
    output      logic            vertex_valid,
    input  wire logic            vertex_ready,
    output      gqg_pkg::vertex_t vertex,
    input  wire logic            cfg_valid,
    output      logic            cfg_ready,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [15:0]     cfg_data
);

    localparam int IDX_W = $clog2(GLYPH_CODES);
    localparam int MW    = gqg_pkg::UV_MUL_W;

    // floor(t * 65536 / SIZE) for t < SIZE is a multiply by a rounded-up
    // reciprocal of the odd part of SIZE followed by a right shift.
    localparam int     U_TZ    = gqg_pkg::trailing_zeros(ATLAS_WIDTH);
    localparam int     U_ODD   = ATLAS_WIDTH >> U_TZ;
    localparam int     U_K     = 13 + $clog2(U_ODD);
    localparam longint U_MUL_L = ((64'sd1 <<< (U_K + 16 - U_TZ)) + U_ODD - 1) / U_ODD;
    localparam logic [MW-1:0] U_MUL = MW'(U_MUL_L);
    localparam int     U_TW    = $clog2(ATLAS_WIDTH);

    localparam int     V_TZ    = gqg_pkg::trailing_zeros(ATLAS_HEIGHT);
    localparam int     V_ODD   = ATLAS_HEIGHT >> V_TZ;
    localparam int     V_K     = 13 + $clog2(V_ODD);
    localparam longint V_MUL_L = ((64'sd1 <<< (V_K + 16 - V_TZ)) + V_ODD - 1) / V_ODD;
    localparam logic [MW-1:0] V_MUL = MW'(V_MUL_L);
    localparam int     V_TW    = $clog2(ATLAS_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  adv_w_reg, adv_h_reg, row_shift_reg, glyph_w_reg, glyph_h_reg;
    logic [7:0]  cell_w_reg, cell_h_reg;
    logic [15:0] glyph_off_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_w_reg     <= 8'd8;
            adv_h_reg     <= 8'd16;
            row_shift_reg <= 8'd0;
            glyph_w_reg   <= 8'd8;
            glyph_h_reg   <= 8'd16;
            cell_w_reg    <= 8'd8;
            cell_h_reg    <= 8'd16;
            glyph_off_reg <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gqg_pkg::CFG_ADVANCE_WIDTH:  adv_w_reg     <= cfg_data[7:0];
                gqg_pkg::CFG_ADVANCE_HEIGHT: adv_h_reg     <= cfg_data[7:0];
                gqg_pkg::CFG_ROW_SHIFT:      row_shift_reg <= cfg_data[7:0];
                gqg_pkg::CFG_GLYPH_WIDTH:    glyph_w_reg   <= cfg_data[7:0];
                gqg_pkg::CFG_GLYPH_HEIGHT:   glyph_h_reg   <= cfg_data[7:0];
                gqg_pkg::CFG_CELL_WIDTH:     cell_w_reg    <= cfg_data[7:0];
                gqg_pkg::CFG_CELL_HEIGHT:    cell_h_reg    <= cfg_data[7:0];
                gqg_pkg::CFG_GLYPH_OFFSET:   glyph_off_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Glyph table: RAM for the entries, flip-flop valid bits for reset
    // ------------------------------------------------------------------
    logic                  item_fire;
    logic                  in_range;
    logic [IDX_W-1:0]      in_idx;
    logic                  table_we;
    gqg_pkg::glyph_entry_t table_wdata;
    gqg_pkg::glyph_entry_t table_rdata;
    logic [GLYPH_CODES-1:0] entry_valid_reg;

    assign item_fire = item_valid && item_ready;
    assign in_range  = ({1'b0, item.char_code} < 9'(GLYPH_CODES));
    assign in_idx    = item.char_code[IDX_W-1:0];
    assign table_we  = item_fire && in_range &&
                       (item.req_type == gqg_pkg::REQ_TABLE_WRITE);

    always_comb
    begin
        table_wdata.mapped = item.cell_mapped;
        table_wdata.row    = item.cell_row;
        table_wdata.col    = item.cell_col;
    end

    gqg_ram #(
        .WIDTH ($bits(gqg_pkg::glyph_entry_t)),
        .DEPTH (GLYPH_CODES)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (in_idx),
        .wdata (table_wdata),
        .re    (item_fire),
        .raddr (in_idx),
        .rdata (table_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (table_we)
        begin
            entry_valid_reg[in_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accepted request and its table lookup
    // ------------------------------------------------------------------
    logic           s1_valid_reg;
    gqg_pkg::item_t s1_item_reg;
    logic           s1_hit_reg;
    logic           s1_emit;
    logic           s1_fire;
    logic           s2_ready;
    logic           is_char;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_item_reg <= item;
            s1_hit_reg  <= in_range && entry_valid_reg[in_idx];
        end
    end

    assign is_char = (s1_item_reg.req_type == gqg_pkg::REQ_CHAR);
    assign s1_emit = is_char && s1_hit_reg && table_rdata.mapped &&
                     (s1_item_reg.char_code != gqg_pkg::CODE_LINEFEED) &&
                     (s1_item_reg.char_code != gqg_pkg::CODE_SPACE);
    assign s1_fire    = s1_valid_reg && (!s1_emit || s2_ready);
    assign item_ready = !s1_valid_reg || s1_fire;

    // ------------------------------------------------------------------
    // String state: origin, color and cursors
    // ------------------------------------------------------------------
    logic [7:0]  cursor_col_reg, cursor_row_reg;
    logic [15:0] base_x_reg, base_y_reg;
    logic [31:0] color_reg;
    logic [7:0]  col_inc, row_inc;

    assign col_inc = (cursor_col_reg == gqg_pkg::CURSOR_MAX) ? cursor_col_reg
                                                              : cursor_col_reg + 8'd1;
    assign row_inc = (cursor_row_reg == gqg_pkg::CURSOR_MAX) ? cursor_row_reg
                                                              : cursor_row_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
            base_x_reg     <= 16'd0;
            base_y_reg     <= 16'd0;
            color_reg      <= 32'd0;
        end
        else if (s1_fire)
        begin
            case (s1_item_reg.req_type)
                gqg_pkg::REQ_STRING_START:
                begin
                    base_x_reg     <= s1_item_reg.origin_x;
                    base_y_reg     <= s1_item_reg.origin_y;
                    color_reg      <= s1_item_reg.text_color;
                    cursor_col_reg <= 8'd0;
                    cursor_row_reg <= 8'd0;
                end
                gqg_pkg::REQ_CHAR:
                begin
                    if (s1_item_reg.char_code == gqg_pkg::CODE_LINEFEED)
                    begin
                        cursor_row_reg <= row_inc;
                        cursor_col_reg <= 8'd0;
                    end
                    else if ((s1_item_reg.char_code == gqg_pkg::CODE_SPACE) || s1_emit)
                    begin
                        cursor_col_reg <= col_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Q18.4 corner coordinates and texel coordinates
    // ------------------------------------------------------------------
    logic [15:0] col_prod, row_prod;
    logic [17:0] row_sum;
    logic [21:0] qx_next, qy_next;
    logic [13:0] tu_prod, tv_prod;
    logic [14:0] tu1_next, tv1_next;
    logic [15:0] tu2_next, tv2_next;

    assign col_prod = 16'(cursor_col_reg) * 16'(adv_w_reg);
    assign row_prod = 16'(cursor_row_reg) * 16'(adv_h_reg);
    assign row_sum  = {2'b00, row_prod} + {{10{row_shift_reg[7]}}, row_shift_reg};
    assign qx_next  = {{6{base_x_reg[15]}}, base_x_reg} + {2'b00, col_prod, 4'b0000};
    assign qy_next  = {{6{base_y_reg[15]}}, base_y_reg} + {row_sum, 4'b0000};

    assign tu_prod  = 14'(table_rdata.col) * 14'(cell_w_reg);
    assign tv_prod  = 14'(table_rdata.row) * 14'(cell_h_reg);
    assign tu1_next = {1'b0, tu_prod} + {7'd0, glyph_off_reg[7:0]};
    assign tv1_next = {1'b0, tv_prod} + {7'd0, glyph_off_reg[15:8]};
    assign tu2_next = {1'b0, tu1_next} + {8'd0, glyph_w_reg};
    assign tv2_next = {1'b0, tv1_next} + {8'd0, glyph_h_reg};

    logic        s2_valid_reg;
    logic [21:0] s2_qx_reg, s2_qy_reg;
    logic [14:0] s2_tu1_reg, s2_tv1_reg;
    logic [15:0] s2_tu2_reg, s2_tv2_reg;
    logic [31:0] s2_color_reg;
    logic        s3_ready;

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_emit)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s3_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_emit)
        begin
            s2_qx_reg    <= qx_next;
            s2_qy_reg    <= qy_next;
            s2_tu1_reg   <= tu1_next;
            s2_tv1_reg   <= tv1_next;
            s2_tu2_reg   <= tu2_next;
            s2_tv2_reg   <= tv2_next;
            s2_color_reg <= color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rounded, clamped corners and normalized UVs
    // ------------------------------------------------------------------
    logic [21:0] qx_half, qy_half;
    logic [17:0] x1_round, y1_round;
    logic [18:0] x2_sum, y2_sum;
    logic [15:0] x1_next, y1_next, x2_next, y2_next;

    // Adding one half and dropping the fraction bits rounds to the nearest pixel, halves up.
    assign qx_half  = s2_qx_reg + 22'd8;
    assign qy_half  = s2_qy_reg + 22'd8;
    assign x1_round = qx_half[21:4];
    assign y1_round = qy_half[21:4];
    assign x2_sum   = {x1_round[17], x1_round} + {11'd0, glyph_w_reg};
    assign y2_sum   = {y1_round[17], y1_round} + {11'd0, glyph_h_reg};
    assign x1_next  = gqg_pkg::sat16({x1_round[17], x1_round});
    assign y1_next  = gqg_pkg::sat16({y1_round[17], y1_round});
    assign x2_next  = gqg_pkg::sat16(x2_sum);
    assign y2_next  = gqg_pkg::sat16(y2_sum);

    logic [U_TW+MW-1:0] u1_prod, u2_prod;
    logic [V_TW+MW-1:0] v1_prod, v2_prod;
    logic [16:0]        u1_next, u2_next, v1_next, v2_next;

    assign u1_prod = (U_TW+MW)'(s2_tu1_reg[U_TW-1:0]) * (U_TW+MW)'(U_MUL);
    assign u2_prod = (U_TW+MW)'(s2_tu2_reg[U_TW-1:0]) * (U_TW+MW)'(U_MUL);
    assign v1_prod = (V_TW+MW)'(s2_tv1_reg[V_TW-1:0]) * (V_TW+MW)'(V_MUL);
    assign v2_prod = (V_TW+MW)'(s2_tv2_reg[V_TW-1:0]) * (V_TW+MW)'(V_MUL);

    // A texel at or past the atlas edge maps to 1.0 or more and saturates.
    assign u1_next = ({1'b0, s2_tu1_reg} >= 16'(ATLAS_WIDTH)) ? gqg_pkg::UV_ONE
                   : {1'b0, u1_prod[U_K+15:U_K]};
    assign u2_next = (s2_tu2_reg >= 16'(ATLAS_WIDTH)) ? gqg_pkg::UV_ONE
                   : {1'b0, u2_prod[U_K+15:U_K]};
    assign v1_next = ({1'b0, s2_tv1_reg} >= 16'(ATLAS_HEIGHT)) ? gqg_pkg::UV_ONE
                   : {1'b0, v1_prod[V_K+15:V_K]};
    assign v2_next = (s2_tv2_reg >= 16'(ATLAS_HEIGHT)) ? gqg_pkg::UV_ONE
                   : {1'b0, v2_prod[V_K+15:V_K]};

    logic        s3_valid_reg;
    logic [2:0]  vcnt_reg;
    logic [15:0] s3_x1_reg, s3_x2_reg, s3_y1_reg, s3_y2_reg;
    logic [16:0] s3_u1_reg, s3_u2_reg, s3_v1_reg, s3_v2_reg;
    logic [31:0] s3_color_reg;
    logic        vertex_fire;
    logic        last_vertex;

    assign vertex_fire = vertex_valid && vertex_ready;
    assign last_vertex = (vcnt_reg == gqg_pkg::LAST_VERTEX);
    assign s3_ready    = !s3_valid_reg || (vertex_ready && last_vertex);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            vcnt_reg     <= 3'd0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (vertex_fire)
            begin
                vcnt_reg <= last_vertex ? 3'd0 : vcnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_x1_reg    <= x1_next;
            s3_x2_reg    <= x2_next;
            s3_y1_reg    <= y1_next;
            s3_y2_reg    <= y2_next;
            s3_u1_reg    <= u1_next;
            s3_u2_reg    <= u2_next;
            s3_v1_reg    <= v1_next;
            s3_v2_reg    <= v2_next;
            s3_color_reg <= s2_color_reg;
        end
    end

    // ------------------------------------------------------------------
    // Vertex order: (x1,y1) (x2,y1) (x2,y2) (x1,y1) (x2,y2) (x1,y2)
    // ------------------------------------------------------------------
    logic sel_far_x, sel_far_y;

    always_comb
    begin
        case (vcnt_reg)
            3'd0:    begin sel_far_x = 1'b0; sel_far_y = 1'b0; end
            3'd1:    begin sel_far_x = 1'b1; sel_far_y = 1'b0; end
            3'd2:    begin sel_far_x = 1'b1; sel_far_y = 1'b1; end
            3'd3:    begin sel_far_x = 1'b0; sel_far_y = 1'b0; end
            3'd4:    begin sel_far_x = 1'b1; sel_far_y = 1'b1; end
            3'd5:    begin sel_far_x = 1'b0; sel_far_y = 1'b1; end
            default: begin sel_far_x = 1'b0; sel_far_y = 1'b0; end
        endcase
    end

    assign vertex_valid = s3_valid_reg;

    always_comb
    begin
        vertex.vertex_x     = sel_far_x ? s3_x2_reg : s3_x1_reg;
        vertex.vertex_y     = sel_far_y ? s3_y2_reg : s3_y1_reg;
        vertex.tex_u        = sel_far_x ? s3_u2_reg : s3_u1_reg;
        vertex.tex_v        = sel_far_y ? s3_v2_reg : s3_v1_reg;
        vertex.vertex_color = s3_color_reg;
        vertex.quad_last    = last_vertex;
    end

endmodule

`default_nettype wire

[sv/gqg_ram.sv]
// ============================================================================
// gqg_ram
// Generic single-clock RAM with one write port and one read port whose read
// data is registered on a read enable.
// ============================================================================
`default_nettype none

module gqg_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/gqg_checker.sv]
// ============================================================================
// gqg_port_checks
// Port-level checks on the vertex channel of the glyph quad generator,
// bound to every instance of the top level.
// ============================================================================
`default_nettype none

module gqg_port_checks (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             vertex_valid,
    input wire logic             vertex_ready,
    input wire gqg_pkg::vertex_t vertex
);

    // A stalled vertex beat keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && !vertex_ready |=> vertex_valid && $stable(vertex))
        else $error("vertex beat changed while stalled");

    // The six vertices of a quad are valid back to back.
    a_quad_burst: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && !vertex.quad_last |=> vertex_valid)
        else $error("vertex missing inside a quad");

    // All vertices of one quad carry the same color.
    a_quad_color: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid && vertex_ready && !vertex.quad_last
        |=> vertex.vertex_color == $past(vertex.vertex_color))
        else $error("color changed inside a quad");

    // Texture coordinates never pass 1.0.
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> (vertex.tex_u <= 17'h10000) && (vertex.tex_v <= 17'h10000))
        else $error("texture coordinate above 1.0");

endmodule

bind glyph_quad_generator_core gqg_port_checks u_gqg_port_checks (.*);

`default_nettype wire

[verif/gqg_checker.sv]
// ============================================================================
// gqg_checker
// Watches the item, vertex and register channels of the glyph quad
// generator. It keeps its own copy of the glyph table, cursors and registers,
// works out the six vertices of every accepted glyph, and compares each
// vertex beat with the oldest outstanding one, field by field.
// ============================================================================

module gqg_checker
    import gqg_pkg::*;
#(
    parameter int GLYPH_CODES  = 256,
    parameter int ATLAS_WIDTH  = 512,
    parameter int ATLAS_HEIGHT = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        vertex_valid,
    input  logic        vertex_ready,
    input  vertex_t     vertex,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    // Corner selection per vertex: bit k set means vertex k uses the far edge.
    localparam logic [5:0] FAR_X = 6'b010110;
    localparam logic [5:0] FAR_Y = 6'b110100;

    logic [7:0]         adv_w;
    logic [7:0]         adv_h;
    logic signed [7:0]  row_shift;
    logic [7:0]         glyph_w;
    logic [7:0]         glyph_h;
    logic [7:0]         cell_w;
    logic [7:0]         cell_h;
    logic [15:0]        glyph_off;

    glyph_entry_t       glyph_map [GLYPH_CODES];
    logic [7:0]         cursor_col;
    logic [7:0]         cursor_row;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [31:0]        string_color;

    vertex_t            vertex_expected [$];

    initial fail_count = 0;
    initial expected_left = 0;

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic signed [15:0] clamp16(input int value);
        if (value > 32767) begin
            return 16'sh7fff;
        end
        if (value < -32768) begin
            return 16'sh8000;
        end
        return 16'(value);
    endfunction

    // Texel position scaled to Q1.16 of the atlas size, truncated, capped at 1.0.
    function automatic logic [16:0] texel_to_uv(input int texel, input int size);
        longint scaled;
        scaled = (longint'(texel) << 16) / size;
        if (scaled > longint'(UV_ONE)) begin
            return UV_ONE;
        end
        return 17'(scaled);
    endfunction

    task automatic restore_defaults();
        adv_w        = 8'd8;
        adv_h        = 8'd16;
        row_shift    = 8'sd0;
        glyph_w      = 8'd8;
        glyph_h      = 8'd16;
        cell_w       = 8'd8;
        cell_h       = 8'd16;
        glyph_off    = 16'd0;
        cursor_col   = 8'd0;
        cursor_row   = 8'd0;
        base_x       = 16'sd0;
        base_y       = 16'sd0;
        string_color = 32'd0;
        for (int code = 0; code < GLYPH_CODES; code++) begin
            glyph_map[code] = '0;
        end
        vertex_expected.delete();
    endtask

    task automatic apply_reg(input logic [2:0] index, input logic [15:0] data);
        case (cfg_reg_e'(index))
            CFG_ADVANCE_WIDTH:  adv_w = data[7:0];
            CFG_ADVANCE_HEIGHT: adv_h = data[7:0];
            CFG_ROW_SHIFT:      row_shift = data[7:0];
            CFG_GLYPH_WIDTH:    glyph_w = data[7:0];
            CFG_GLYPH_HEIGHT:   glyph_h = data[7:0];
            CFG_CELL_WIDTH:     cell_w = data[7:0];
            CFG_CELL_HEIGHT:    cell_h = data[7:0];
            CFG_GLYPH_OFFSET:   glyph_off = data;
            default: ;
        endcase
    endtask

    task automatic emit_quad(input glyph_entry_t entry);
        int                 qx;
        int                 qy;
        int                 x_pix;
        int                 y_pix;
        int                 texel_u;
        int                 texel_v;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic [16:0]        u1;
        logic [16:0]        u2;
        logic [16:0]        v1;
        logic [16:0]        v2;
        vertex_t            corner;

        qx = int'(base_x) + 16 * (int'(cursor_col) * int'(adv_w));
        qy = int'(base_y) + 16 * (int'(cursor_row) * int'(adv_h) + int'(row_shift));
        // An arithmetic shift floors, so halves round toward plus infinity.
        x_pix = (qx + 8) >>> 4;
        y_pix = (qy + 8) >>> 4;
        x1 = clamp16(x_pix);
        y1 = clamp16(y_pix);
        x2 = clamp16(x_pix + int'(glyph_w));
        y2 = clamp16(y_pix + int'(glyph_h));

        texel_u = int'(entry.col) * int'(cell_w) + int'(glyph_off[7:0]);
        texel_v = int'(entry.row) * int'(cell_h) + int'(glyph_off[15:8]);
        u1 = texel_to_uv(texel_u, ATLAS_WIDTH);
        u2 = texel_to_uv(texel_u + int'(glyph_w), ATLAS_WIDTH);
        v1 = texel_to_uv(texel_v, ATLAS_HEIGHT);
        v2 = texel_to_uv(texel_v + int'(glyph_h), ATLAS_HEIGHT);

        for (int k = 0; k < 6; k++) begin
            corner.vertex_x     = FAR_X[k] ? x2 : x1;
            corner.vertex_y     = FAR_Y[k] ? y2 : y1;
            corner.tex_u        = FAR_X[k] ? u2 : u1;
            corner.tex_v        = FAR_Y[k] ? v2 : v1;
            corner.vertex_color = string_color;
            corner.quad_last    = (k == int'(LAST_VERTEX));
            vertex_expected = {vertex_expected, corner};
        end
        if (cursor_col != CURSOR_MAX) begin
            cursor_col++;
        end
    endtask

    task automatic predict_item(input item_t req);
        glyph_entry_t entry;
        case (req.req_type)
            REQ_TABLE_WRITE: begin
                if (int'(req.char_code) < GLYPH_CODES) begin
                    entry.mapped = req.cell_mapped;
                    entry.row    = req.cell_row;
                    entry.col    = req.cell_col;
                    glyph_map[req.char_code] = entry;
                end
            end
            REQ_STRING_START: begin
                base_x       = req.origin_x;
                base_y       = req.origin_y;
                string_color = req.text_color;
                cursor_col   = 8'd0;
                cursor_row   = 8'd0;
            end
            REQ_CHAR: begin
                if (req.char_code == CODE_LINEFEED) begin
                    if (cursor_row != CURSOR_MAX) begin
                        cursor_row++;
                    end
                    cursor_col = 8'd0;
                end
                else if (req.char_code == CODE_SPACE) begin
                    if (cursor_col != CURSOR_MAX) begin
                        cursor_col++;
                    end
                end
                else if (int'(req.char_code) < GLYPH_CODES) begin
                    entry = glyph_map[req.char_code];
                    if (entry.mapped) begin
                        emit_quad(entry);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_vertex(input vertex_t got);
        vertex_t want;
        if (vertex_expected.size() == 0) begin
            report_error($sformatf("vertex beat with none outstanding: %h", got));
            return;
        end
        want = vertex_expected.pop_front();
        if (got.vertex_x !== want.vertex_x) begin
            report_error($sformatf("vertex_x got %0d expected %0d",
                                   got.vertex_x, want.vertex_x));
        end
        if (got.vertex_y !== want.vertex_y) begin
            report_error($sformatf("vertex_y got %0d expected %0d",
                                   got.vertex_y, want.vertex_y));
        end
        if (got.tex_u !== want.tex_u) begin
            report_error($sformatf("tex_u got %h expected %h", got.tex_u, want.tex_u));
        end
        if (got.tex_v !== want.tex_v) begin
            report_error($sformatf("tex_v got %h expected %h", got.tex_v, want.tex_v));
        end
        if (got.vertex_color !== want.vertex_color) begin
            report_error($sformatf("vertex_color got %h expected %h",
                                   got.vertex_color, want.vertex_color));
        end
        if (got.quad_last !== want.quad_last) begin
            report_error($sformatf("quad_last got %b expected %b",
                                   got.quad_last, want.quad_last));
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            restore_defaults();
        end
        else begin
            if (vertex_valid && vertex_ready) begin
                check_vertex(vertex);
            end
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            if (item_valid && item_ready) begin
                predict_item(item);
            end
        end
        expected_left = vertex_expected.size();
    end

endmodule

[verif/testbench.sv]
// ============================================================================
// testbench
// Drives the glyph quad generator with table writes, string starts and
// characters under several register settings, with random idling on both
// channels, and reports the verdict of the checker beside the block.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gqg_pkg::*;

    localparam int GLYPH_CODES  = 256;
    localparam int ATLAS_WIDTH  = 512;
    localparam int ATLAS_HEIGHT = 512;

    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
    localparam logic [7:0] CHAR_LOW      = 8'h00;
    localparam logic [7:0] CHAR_LETTER   = 8'h41;
    localparam logic [7:0] CHAR_HIGH     = 8'hff;
    localparam int         IDLE_PCT      = 8;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         STALL_LIMIT   = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        vertex_valid;
    logic        vertex_ready = 1'b0;
    vertex_t     vertex;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          fail_count;
    int          expected_left;
    bit          steady_flow = 1'b0;
    logic [7:0]  mapped_codes [$];

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    glyph_quad_generator_core #(
        .GLYPH_CODES  (GLYPH_CODES),
        .ATLAS_WIDTH  (ATLAS_WIDTH),
        .ATLAS_HEIGHT (ATLAS_HEIGHT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gqg_checker #(
        .GLYPH_CODES  (GLYPH_CODES),
        .ATLAS_WIDTH  (ATLAS_WIDTH),
        .ATLAS_HEIGHT (ATLAS_HEIGHT)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .vertex_valid  (vertex_valid),
        .vertex_ready  (vertex_ready),
        .vertex        (vertex),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always @(negedge clk) begin
        vertex_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // Ends the run when no beat moves on any channel for too long.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (vertex_valid && vertex_ready)
                    || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end
            else begin
                stall_cycles++;
            end
        end
        $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // A request with every payload bit random, then the type and code forced.
    function automatic item_t request(input logic [1:0] req, input logic [7:0] code);
        logic [95:0] noise;
        item_t       r;
        noise = {$urandom, $urandom, $urandom};
        r = noise[$bits(item_t)-1:0];
        r.req_type  = req;
        r.char_code = code;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input item_t req);
        while (!steady_flow && ($urandom_range(99, 0) < IDLE_PCT)) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item = req;
        @(posedge clk);
        while (!item_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_glyph(input logic [7:0] code, input logic [5:0] col,
                               input logic [5:0] row, input logic mapped);
        item_t req;
        req = request(REQ_TABLE_WRITE, code);
        req.cell_col    = col;
        req.cell_row    = row;
        req.cell_mapped = mapped;
        if (mapped) begin
            mapped_codes = {mapped_codes, code};
        end
        send_item(req);
    endtask

    task automatic start_string(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic [31:0] color);
        item_t req;
        req = request(REQ_STRING_START, CHAR_LOW);
        req.origin_x   = x;
        req.origin_y   = y;
        req.text_color = color;
        send_item(req);
    endtask

    task automatic send_char(input logic [7:0] code);
        send_item(request(REQ_CHAR, code));
    endtask

    // Holds the sender until every outstanding vertex is out and the
    // pipeline has had time to flush any glyph that makes no vertex.
    task automatic drain_vertices();
        item_valid = 1'b0;
        while (expected_left != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_registers(input logic [15:0] values [8]);
        cfg_valid = 1'b1;
        for (int r = 0; r < 8; r++) begin
            cfg_index = r[2:0];
            cfg_data  = values[r];
            @(posedge clk);
            while (!cfg_ready) begin
                @(posedge clk);
            end
            @(negedge clk);
        end
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int count);
        item_t req;
        int    roll;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                drain_vertices();
            end
            roll = $urandom_range(99, 0);
            req = request(REQ_CHAR, 8'($urandom));
            if (roll < 6) begin
                req.req_type    = REQ_TABLE_WRITE;
                req.cell_mapped = ($urandom_range(99, 0) < 85);
                if (req.cell_mapped) begin
                    mapped_codes = {mapped_codes, req.char_code};
                end
            end
            else if (roll < 14) begin
                req.req_type = REQ_STRING_START;
            end
            else if (roll < 24) begin
                req.char_code = CODE_SPACE;
            end
            else if (roll < 32) begin
                req.char_code = CODE_LINEFEED;
            end
            else if (roll < 35) begin
                req.req_type = REQ_UNKNOWN;
            end
            else if ((mapped_codes.size() != 0) && ($urandom_range(99, 0) < 75)) begin
                req.char_code = mapped_codes[$urandom_range(mapped_codes.size() - 1, 0)];
            end
            send_item(req);
        end
    endtask

    initial begin
        logic [15:0] regs [8];

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset register values.
        send_char(CHAR_LETTER);
        write_glyph(CHAR_LETTER, 6'd63, 6'd63, 1'b1);
        write_glyph(CHAR_LOW, 6'd0, 6'd0, 1'b1);
        write_glyph(CHAR_HIGH, 6'd1, 6'd2, 1'b1);
        write_glyph(CODE_LINEFEED, 6'd3, 6'd3, 1'b1);
        write_glyph(CODE_SPACE, 6'd4, 6'd4, 1'b1);
        send_char(CHAR_LETTER);
        start_string(16'sh7fff, 16'sh8000, 32'hffff_ffff);
        send_char(CHAR_LOW);
        send_char(CHAR_HIGH);
        send_char(CHAR_LETTER);
        send_char(CODE_SPACE);
        send_char(CODE_LINEFEED);
        send_item(request(REQ_UNKNOWN, CHAR_LETTER));
        // Half-pixel origins check the rounding on both sides of zero.
        start_string(16'shfff8, 16'sh0018, 32'h0000_0000);
        send_char(CHAR_LETTER);
        start_string(16'shffe8, 16'sh0007, 32'ha5a5_5a5a);
        send_char(CHAR_LETTER);
        write_glyph(CHAR_LETTER, 6'd10, 6'd20, 1'b0);
        send_char(CHAR_LETTER);
        write_glyph(CHAR_LETTER, 6'd5, 6'd7, 1'b1);

        // Move both cursors away from the origin.
        start_string(16'sh0000, 16'sh0000, 32'h1234_5678);
        repeat (3) send_char(CODE_SPACE);
        send_char(CHAR_LETTER);
        repeat (2) send_char(CODE_LINEFEED);
        send_char(CHAR_LETTER);
        send_char(CHAR_LETTER);
        drain_vertices();

        // Every register at its top value, row shift at its most negative.
        regs = '{default: 16'hffff};
        regs[CFG_ROW_SHIFT] = 16'hff80;
        load_registers(regs);
        run_random(45);
        drain_vertices();

        // Every register at zero, row shift at its most positive, no idling.
        regs = '{default: 16'h0000};
        regs[CFG_ROW_SHIFT] = 16'h007f;
        load_registers(regs);
        steady_flow = 1'b1;
        run_random(45);
        steady_flow = 1'b0;
        drain_vertices();

        // Font-like sizes, so that most UVs stay inside the atlas.
        regs[CFG_ADVANCE_WIDTH]  = {8'($urandom), 8'($urandom_range(16, 4))};
        regs[CFG_ADVANCE_HEIGHT] = {8'($urandom), 8'($urandom_range(24, 8))};
        regs[CFG_ROW_SHIFT]      = 16'($urandom);
        regs[CFG_GLYPH_WIDTH]    = {8'($urandom), 8'($urandom_range(32, 1))};
        regs[CFG_GLYPH_HEIGHT]   = {8'($urandom), 8'($urandom_range(32, 1))};
        regs[CFG_CELL_WIDTH]     = {8'($urandom), 8'($urandom_range(16, 1))};
        regs[CFG_CELL_HEIGHT]    = {8'($urandom), 8'($urandom_range(16, 1))};
        regs[CFG_GLYPH_OFFSET]   = {8'($urandom_range(15, 0)), 8'($urandom_range(15, 0))};
        load_registers(regs);
        run_random(45);
        drain_vertices();

        for (int r = 0; r < 8; r++) begin
            regs[r] = 16'($urandom);
        end
        load_registers(regs);
        run_random(45);
        drain_vertices();

        if ((fail_count == 0) && (expected_left == 0)) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
